// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/frpf_pkg.sv =====
// Shared types, widths and codes of the fixed-radius pair finder.
package frpf_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = 6;
  localparam int RESULT_CAP = 63;
  localparam int HIT_W      = $clog2(RESULT_CAP + 1);
  localparam int RADIUS_W   = 33;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int D2_W       = 2 * COORD_BITS + 1;
  localparam int ROOT_W     = (D2_W + 1) / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int STEP_W     = $clog2(ROOT_W + 1);
  localparam int DIST_W     = 17;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 64;
  localparam int REG_IDX_W  = 1;

  // Register index, taken from the 8-byte word select of paddr
  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 1'b0;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  // Control of the shared squarer
  typedef struct packed {
    logic square_x;   // load acc with dx*dx
    logic square_y;   // add dy*dy into acc
  } dist_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SQX,
    ST_SQY,
    ST_CMP,
    ST_ROOT,
    ST_EMIT,
    ST_NEXT,
    ST_FLUSH,
    ST_WRITE
  } state_t;

endpackage

// ===== sv/frpf_if.sv =====
// Valid/ready channel interfaces for points in and pairs out.
interface frpf_point_if;
  import frpf_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   new_set;

  modport source (output valid, output point_x, output point_y, output new_set, input ready);
  modport sink   (input valid, input point_x, input point_y, input new_set, output ready);
endinterface

interface frpf_pair_if;
  import frpf_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  first_index;
  logic [IDX_W-1:0]  second_index;
  logic [DIST_W-1:0] distance;
  logic              last_of_run;

  modport source (output valid, output first_index, output second_index, output distance,
                  output last_of_run, input ready);
  modport sink   (input valid, input first_index, input second_index, input distance,
                  input last_of_run, output ready);
endinterface

// ===== sv/frpf_point_mem.sv =====
// Point store: one write port, one registered read port.
module frpf_point_mem (
  input  logic                  clk,
  input  logic                  we,
  input  logic [frpf_pkg::ADDR_W-1:0] waddr,
  input  frpf_pkg::point_t      wdata,
  input  logic [frpf_pkg::ADDR_W-1:0] raddr,
  output frpf_pkg::point_t      rdata
);
  import frpf_pkg::*;

  point_t mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/frpf_dist_unit.sv =====
// Shared squarer and accumulator: squared distance and radius compare.
module frpf_dist_unit (
  input  logic                        clk,
  input  frpf_pkg::dist_ctl_t         ctl,
  input  frpf_pkg::point_t            cur,
  input  frpf_pkg::point_t            stored,
  input  logic [frpf_pkg::RADIUS_W-1:0] radius,
  output logic [frpf_pkg::D2_W-1:0]   d2,
  output logic                        hit
);
  import frpf_pkg::*;

  coord_t              op_a;
  coord_t              op_b;
  logic [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]   mag;
  logic [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]     sq;

  // Pick the axis, then take the magnitude of the difference
  always_comb begin
    op_a = ctl.square_y ? cur.y : cur.x;
    op_b = ctl.square_y ? stored.y : stored.x;
    diff = {op_a[COORD_BITS-1], op_a} - {op_b[COORD_BITS-1], op_b};
    mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
    prod = mag * mag;
    sq   = prod[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.square_x) begin
      d2 <= D2_W'(sq);
    end else if (ctl.square_y) begin
      d2 <= d2 + D2_W'(sq);
    end
  end

  assign hit = d2 < radius;

endmodule

// ===== sv/frpf_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module frpf_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [frpf_pkg::D2_W-1:0] value,
  output logic                      done,
  output logic [frpf_pkg::ROOT_W-1:0] root
);
  import frpf_pkg::*;

  logic [2*ROOT_W-1:0] rad;
  logic [REM_W-1:0]    rem;
  logic [STEP_W-1:0]   step;
  logic                busy;
  logic [REM_W-1:0]    rem_shift;
  logic [REM_W-1:0]    trial;
  logic                take;

  always_comb begin
    rem_shift = {rem[REM_W-3:0], rad[2*ROOT_W-1 -: 2]};
    trial     = {root, 2'b01};
    take      = rem_shift >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(ROOT_W);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= (2*ROOT_W)'(value);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[2*ROOT_W-3:0], 2'b00};
      rem  <= take ? (rem_shift - trial) : rem_shift;
      root <= {root[ROOT_W-2:0], take};
    end
  end

endmodule

// ===== sv/fixed_radius_pair_finder_top.sv =====
// Fixed-radius pair finder: each point is compared with the n stored points of its set; the
// first point of a set is stored without a scan, and a point that finds the store full is dropped.
// Points are taken one at a time; point.ready is high only between items.
// Rate is set by the single shared squarer (read, square x, square y, compare and next states
// per stored point) and the 17-step root unit run once per close pair; pair stalls add to it.
// Reset clears the state machine, point count, radius and output; the store is not cleared.
module fixed_radius_pair_finder_top (
  input  logic                          clk,
  input  logic                          rst,
  frpf_point_if.sink                    point,
  frpf_pair_if.source                   pair,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frpf_pkg::PADDR_W-1:0]  paddr,
  input  logic [frpf_pkg::PDATA_W-1:0]  pwdata,
  output logic [frpf_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import frpf_pkg::*;

  // Sequencer and run state
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   cnt_eff;
  point_t             cur;
  logic [ADDR_W-1:0]  new_idx;
  logic [ADDR_W-1:0]  scan_idx;
  logic [HIT_W-1:0]   hits;
  logic [RADIUS_W-1:0] radius;

  // One close pair held back until we know whether it is the last of the run
  logic               pend_valid;
  logic [ADDR_W-1:0]  pend_first;
  logic [ROOT_W-1:0]  pend_dist;

  // Output register
  logic               out_valid;
  logic [IDX_W-1:0]   out_first;
  logic [IDX_W-1:0]   out_second;
  logic [DIST_W-1:0]  out_dist;
  logic               out_last;

  // Datapath links
  point_t             stored;
  dist_ctl_t          dctl;
  logic [D2_W-1:0]    d2;
  logic               hit;
  logic               root_start;
  logic               root_done;
  logic [ROOT_W-1:0]  root;
  logic               mem_we;
  logic               accept;
  logic               out_free;
  logic               load_out;
  logic               load_last;
  logic               cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration port: one 64-bit word, selected by paddr bit 3
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (cfg_write && (paddr[PADDR_W-1 -: REG_IDX_W] == REG_RADIUS)) begin
      radius <= pwdata[RADIUS_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1 -: REG_IDX_W] == REG_RADIUS) ? PDATA_W'(radius) : '0;

  // ---------------------------------------------------------------------------
  // Datapath units
  // ---------------------------------------------------------------------------
  frpf_point_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (new_idx),
    .wdata (cur),
    .raddr (scan_idx),
    .rdata (stored)
  );

  frpf_dist_unit u_dist (
    .clk    (clk),
    .ctl    (dctl),
    .cur    (cur),
    .stored (stored),
    .radius (radius),
    .d2     (d2),
    .hit    (hit)
  );

  frpf_isqrt u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (d2),
    .done  (root_done),
    .root  (root)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign point.ready = (state == ST_IDLE);
  assign accept      = point.valid && point.ready;
  assign cnt_eff     = point.new_set ? '0 : count;
  assign out_free    = !out_valid || pair.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dctl       = '0;
    root_start = 1'b0;
    mem_we     = 1'b0;
    load_out   = 1'b0;
    load_last  = 1'b0;
    case (state)
      ST_IDLE: begin
        // Drop a point that finds the store full
        if (accept && (cnt_eff < CNT_W'(MAX_POINTS))) begin
          state_next = (cnt_eff == '0) ? ST_WRITE : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SQX;
      end
      ST_SQX: begin
        dctl.square_x = 1'b1;
        state_next    = ST_SQY;
      end
      ST_SQY: begin
        dctl.square_y = 1'b1;
        state_next    = ST_CMP;
      end
      ST_CMP: begin
        if (hit) begin
          root_start = 1'b1;
          state_next = ST_ROOT;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold while the held pair cannot move on to the output
        if (!pend_valid) begin
          state_next = ST_NEXT;
        end else if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if ((scan_idx == new_idx - ADDR_W'(1)) || (hits == HIT_W'(RESULT_CAP))) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_WRITE;
        end else if (out_free) begin
          load_out   = 1'b1;
          load_last  = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we     = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Run bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= cnt_eff;
      end
      if (state == ST_WRITE) begin
        count <= CNT_W'(new_idx) + CNT_W'(1);
      end
      if (state == ST_EMIT && (!pend_valid || out_free)) begin
        pend_valid <= 1'b1;
      end else if (state == ST_FLUSH && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur.x    <= point.point_x;
      cur.y    <= point.point_y;
      new_idx  <= cnt_eff[ADDR_W-1:0];
      scan_idx <= '0;
      hits     <= '0;
    end
    if (state == ST_NEXT) begin
      scan_idx <= scan_idx + ADDR_W'(1);
    end
    // Advance the held pair whenever a new close pair is taken in
    if (state == ST_EMIT && (!pend_valid || out_free)) begin
      pend_first <= scan_idx;
      pend_dist  <= root;
      hits       <= hits + HIT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: a new transfer loads it only when it is empty or being taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pair.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_first  <= pend_first[IDX_W-1:0];
      out_second <= new_idx[IDX_W-1:0];
      out_dist   <= DIST_W'(pend_dist);
      out_last   <= load_last;
    end
  end

  assign pair.valid        = out_valid;
  assign pair.first_index  = out_first;
  assign pair.second_index = out_second;
  assign pair.distance     = out_dist;
  assign pair.last_of_run  = out_last;

endmodule

// ===== sv/frpf_checker.sv =====
// Port-level checker for the pair finder, bound to the top level.
`include "assert_macros.svh"

module frpf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          point_valid,
  input logic                          point_ready,
  input logic                          new_set,
  input logic                          pair_valid,
  input logic                          pair_ready,
  input logic [frpf_pkg::IDX_W-1:0]    first_index,
  input logic [frpf_pkg::IDX_W-1:0]    second_index,
  input logic [frpf_pkg::DIST_W-1:0]   distance,
  input logic                          last_of_run
);
  import frpf_pkg::*;

  // A stalled pair must hold its payload
  `CHK_ASSERT(a_pair_hold, clk, rst, pair_valid && !pair_ready |=> pair_valid && $stable(first_index) && $stable(second_index) && $stable(distance) && $stable(last_of_run), "stalled pair changed")

  // The earlier point always has the lower index
  `CHK_ASSERT(a_pair_order, clk, rst, pair_valid |-> first_index < second_index, "pair indices out of order")

  // A point that opens a new set is always stored, so the next point waits
  `CHK_ASSERT(a_busy_after_point, clk, rst, point_valid && point_ready && new_set |=> !point_ready, "ready stayed high after a new set")

  // Reset empties the output register
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !pair_valid, "pair valid after reset")

endmodule

bind fixed_radius_pair_finder_top frpf_checker u_frpf_checker (
  .clk          (clk),
  .rst          (rst),
  .point_valid  (point.valid),
  .point_ready  (point.ready),
  .new_set      (point.new_set),
  .pair_valid   (pair.valid),
  .pair_ready   (pair.ready),
  .first_index  (pair.first_index),
  .second_index (pair.second_index),
  .distance     (pair.distance),
  .last_of_run  (pair.last_of_run)
);

// ===== test/frpf_pair_checker.sv =====
`timescale 1ns / 1ps
// Pair checker: watches the point, pair and register ports, predicts close pairs and compares.
module frpf_pair_checker (
  input  logic                         clk,
  input  logic                         rst,
  frpf_point_if                        pt,
  frpf_pair_if                         pr,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [frpf_pkg::PADDR_W-1:0] paddr,
  input  logic [frpf_pkg::PDATA_W-1:0] pwdata,
  input  logic [frpf_pkg::PDATA_W-1:0] prdata,
  output int                           errors,
  output int                           pairs_pending,
  output int                           points_taken,
  output int                           points_dropped,
  output int                           pairs_checked
);
  import frpf_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [DIST_W-1:0] distance;
    logic              last_of_run;
  } close_pair_t;

  close_pair_t         expected_pairs[$];
  coord_t              kept_x [MAX_POINTS];
  coord_t              kept_y [MAX_POINTS];
  int unsigned         kept_count = 0;
  logic [RADIUS_W-1:0] radius_sq = '0;
  int                  fail_count = 0;
  int                  pending_count = 0;
  int                  taken_count = 0;
  int                  dropped_count = 0;
  int                  checked_count = 0;

  assign errors         = fail_count;
  assign pairs_pending  = pending_count;
  assign points_taken   = taken_count;
  assign points_dropped = dropped_count;
  assign pairs_checked  = checked_count;

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) note_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
  endtask

  // Integer square root, rounded down, one result bit at a time
  function automatic logic [DIST_W-1:0] floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[DIST_W-1:0];
  endfunction

  // Store the new point, unless the store is full, and queue every close pair it makes with the earlier ones
  task automatic predict_pairs(coord_t x, coord_t y, logic fresh);
    close_pair_t     found[$];
    close_pair_t     rec;
    longint          dx;
    longint          dy;
    longint unsigned d2;
    if (fresh) kept_count = 0;
    if (kept_count >= MAX_POINTS) begin
      dropped_count++;
      return;
    end
    for (int i = 0; i < kept_count && found.size() < RESULT_CAP; i++) begin
      dx = longint'(x) - longint'(kept_x[i]);
      dy = longint'(y) - longint'(kept_y[i]);
      d2 = dx * dx + dy * dy;
      if (d2 < {31'b0, radius_sq}) begin
        rec.first_index  = IDX_W'(i);
        rec.second_index = IDX_W'(kept_count);
        rec.distance     = floor_root(d2);
        rec.last_of_run  = 1'b0;
        found = {found, rec};
      end
    end
    if (found.size() > 0) found[found.size() - 1].last_of_run = 1'b1;
    foreach (found[k]) expected_pairs = {expected_pairs, found[k]};
    kept_x[kept_count] = x;
    kept_y[kept_count] = y;
    kept_count++;
    taken_count++;
  endtask

  always @(posedge clk) begin
    close_pair_t want;
    if (rst) begin
      kept_count = 0;
      radius_sq  = '0;
    end else begin
      // drain pairs before queueing those of a point taken on the same edge
      if (pr.valid && pr.ready) begin
        if (expected_pairs.size() == 0) begin
          note_failure($sformatf("pair %0d-%0d distance %0d with none outstanding",
                                 pr.first_index, pr.second_index, pr.distance));
        end else begin
          want = expected_pairs.pop_front();
          check_field("first_index", want.first_index, pr.first_index);
          check_field("second_index", want.second_index, pr.second_index);
          check_field("distance", want.distance, pr.distance);
          check_field("last_of_run", want.last_of_run, pr.last_of_run);
          checked_count++;
        end
      end
      if (pt.valid && pt.ready) predict_pairs(pt.point_x, pt.point_y, pt.new_set);
      if (psel && penable && pready && paddr[PADDR_W-1:3] == REG_RADIUS) begin
        if (pwrite) radius_sq = pwdata[RADIUS_W-1:0];
        else check_field("radius_squared readback", PDATA_W'(radius_sq), prdata);
      end
    end
    pending_count = expected_pairs.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: drives points, pair back-pressure and radius writes, and gives the verdict.
module tb_top;
  import frpf_pkg::*;

  // Largest squared distance two points can have; a radius this size catches all but that one
  localparam longint unsigned   RADIUS_MAX  = 64'd8589672450;
  localparam logic [PADDR_W-1:0] RADIUS_ADDR = PADDR_W'({REG_RADIUS, 3'b000});
  // A point with no pairs still walks the whole store
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASES        = 8;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_BURSTY
  } rx_mode_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int errors;
  int pairs_pending;
  int points_taken;
  int points_dropped;
  int pairs_checked;
  int burst_left = 0;
  int radius_writes = 0;

  frpf_point_if pt_if ();
  frpf_pair_if  pr_if ();

  fixed_radius_pair_finder_top dut (
    .clk     (clk),
    .rst     (rst),
    .point   (pt_if),
    .pair    (pr_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frpf_pair_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .pt             (pt_if),
    .pr             (pr_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .errors         (errors),
    .pairs_pending  (pairs_pending),
    .points_taken   (points_taken),
    .points_dropped (points_dropped),
    .pairs_checked  (pairs_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop, sized for every point making 63 pairs each behind the longest stall, and more
  initial begin
    #25_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Pair back-pressure: switch between always ready, coin flips and bursts of stalls
  initial begin
    rx_mode_t mode;
    int       span;
    int       stall_left;
    pr_if.ready = 1'b0;
    stall_left  = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 2));
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_STEADY: begin
            pr_if.ready <= 1'b1;
          end
          RX_COIN: begin
            pr_if.ready <= $urandom_range(0, 1);
          end
          default: begin
            if (stall_left > 0) begin
              pr_if.ready <= 1'b0;
              stall_left--;
            end else begin
              pr_if.ready <= 1'b1;
              if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 7);
            end
          end
        endcase
      end
    end
  end

  // One APB transfer to the radius register: setup cycle, then access until pready
  task automatic apb_access(logic wr, logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= RADIUS_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the radius and read it back; the checker compares the readback
  task automatic set_radius(longint unsigned r);
    apb_access(1'b1, PDATA_W'(r));
    apb_access(1'b0, '0);
    radius_writes++;
  endtask

  // Drop valid, wait for every outstanding pair, then let a pairless point finish its walk
  task automatic settle();
    @(negedge clk);
    pt_if.valid <= 1'b0;
    wait (pairs_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Offer one point and hold it until the transfer; the sender works in bursts with gaps
  task automatic send_point(coord_t x, coord_t y, logic fresh);
    int gap;
    @(negedge clk);
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= x;
    pt_if.point_y <= y;
    pt_if.new_set <= fresh;
    do @(posedge clk); while (!pt_if.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      pt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // A coordinate within spread of the centre, clamped to the signed range
  function automatic coord_t near(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  // Clustered sets of random length; a few stray points and a few early set restarts mixed in
  task automatic run_sets(int target, int spread);
    int     sent;
    int     set_len;
    int     cx;
    int     cy;
    coord_t x;
    coord_t y;
    logic   fresh;
    sent = 0;
    while (sent < target) begin
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(2, 10);
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
      for (int k = 0; k < set_len; k++) begin
        fresh = (k == 0) || ($urandom_range(0, 29) == 0);
        if ($urandom_range(0, 15) == 0) begin
          x = coord_t'($urandom);
          y = coord_t'($urandom);
        end else begin
          x = near(cx, spread);
          y = near(cy, spread);
        end
        send_point(x, y, fresh);
        sent++;
      end
    end
  endtask

  initial begin
    longint unsigned r;
    int              spread;
    rst           = 1'b1;
    pt_if.valid   = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.new_set = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);

    // Zero radius: nothing is close, not even a repeated point
    set_radius(0);
    send_point(16'sh8000, 16'sh7FFF, 1'b1);
    send_point(16'sh7FFF, 16'sh8000, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    settle();

    // Widest radius: corner points, full-span distances, the diagonal just outside the limit
    set_radius(RADIUS_MAX);
    send_point(16'sh8000, 16'sh8000, 1'b1);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_point(16'sh7FFF, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sh5555, 16'shAAAA, 1'b0);
    send_point(16'shAAAA, 16'sh5555, 1'b0);
    settle();

    // Radius one: only coincident points pair up; distance one sits on the boundary
    set_radius(1);
    send_point(16'sd100, -16'sd100, 1'b1);
    send_point(16'sd100, -16'sd100, 1'b0);
    send_point(16'sd101, -16'sd100, 1'b0);
    send_point(16'sd100, -16'sd100, 1'b0);
    settle();

    // Radius two: the unit diagonal is excluded, unit steps are in
    set_radius(2);
    send_point(16'sd5, 16'sd5, 1'b1);
    send_point(16'sd6, 16'sd6, 1'b0);
    send_point(16'sd6, 16'sd5, 1'b0);
    settle();

    // Fill the store completely, so the last point pairs with all 63, then overflow it
    set_radius(RADIUS_MAX);
    for (int k = 0; k < MAX_POINTS + 3; k++) begin
      send_point(coord_t'($urandom), coord_t'($urandom), k == 0);
    end
    settle();

    // Random phases, the cluster spread matched to the radius so that pairs are common
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          r = $urandom_range(0, 64);
          spread = 8;
        end
        1: begin
          r = $urandom_range(64, 4096);
          spread = 64;
        end
        2: begin
          r = $urandom_range(10000, 1000000);
          spread = 1024;
        end
        3: begin
          r = $urandom_range(100000000, 32'hFFFF_FFFF);
          spread = 32767;
        end
        4: begin
          r = RADIUS_MAX;
          spread = 32767;
        end
        5: begin
          r = 0;
          spread = 8;
        end
        6: begin
          r = {31'b0, 1'($urandom_range(0, 1)), 32'($urandom)};
          if (r > RADIUS_MAX) r = RADIUS_MAX;
          spread = 32767;
        end
        default: begin
          r = $urandom_range(100, 2000);
          spread = 16;
        end
      endcase
      set_radius(r);
      run_sets(30, spread);
      settle();
    end

    $display("Run covered %0d points taken and %0d dropped at a full store,", points_taken,
             points_dropped);
    $display("with %0d close pairs checked over %0d radius settings.", pairs_checked,
             radius_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
